@@ rtl/srfc_pkg.sv @@
// Package with the constants, types and CRC helper of the sensor reply frame checker.
`timescale 1ns / 1ps
`default_nettype none

package srfc_pkg;

  localparam int unsigned MaxFrame = 16;
  localparam int unsigned PosW     = 5;

  localparam logic [PosW-1:0] MaxFramePos = PosW'(MaxFrame);

  localparam logic [7:0]  SyncFirst        = 8'hBB;
  localparam logic [7:0]  SyncSecond       = 8'h66;
  localparam logic [7:0]  ReadingCodeReset = 8'h15;
  localparam logic [15:0] CrcPoly          = 16'hA001;
  localparam logic [15:0] CrcInit          = 16'hFFFF;

  // Per-reply state that is carried from byte to byte.
  typedef struct packed {
    logic [15:0]     crc;
    logic [PosW-1:0] pos;
    logic [7:0]      older;
    logic [7:0]      newer;
    logic            sync;
    logic [7:0]      code;
    logic [7:0]      rd_high;
    logic [7:0]      rd_low;
  } frame_state_t;

  localparam frame_state_t FrameClear = '{
    crc:     CrcInit,
    pos:     '0,
    older:   '0,
    newer:   '0,
    sync:    1'b0,
    code:    '0,
    rd_high: '0,
    rd_low:  '0
  };

  // Reflected CRC-16 update over one byte, bit loop unrolled.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] data);
    logic [15:0] crc;
    crc = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (crc[0]) begin
        crc = (crc >> 1) ^ CrcPoly;
      end else begin
        crc = crc >> 1;
      end
    end
    return crc;
  endfunction

endpackage

`default_nettype wire

@@ rtl/sensor_reply_frame_checker.sv @@
// Top level of the sensor reply frame checker: sync and CRC-16 check with reading extraction.
//
//   channel  | direction | handshake             | payload
//   ---------+-----------+-----------------------+-------------------------------------------
//   in       | input     | in_valid_i/in_ready_o | rx_byte_i, end_of_frame_i
//   out      | output    | out_valid_o/out_ready_i | frame_good_o, frame_length_o, reading_o
//   cfg      | input     | cfg_valid_i/cfg_ready_o | reading_code_i
//
// One byte is taken per cycle unless a last byte waits on a full result register. A result
// goes from the input register via the byte-wide CRC update and checks to the result slot.
// The input register drains into the frame state every cycle unless it holds a last byte
// while the result register is full and not being taken.
// Reset clears the frame state, both valid flags and sets reading_code to 0x15.
// The configuration port is always ready.
`timescale 1ns / 1ps
`default_nettype none

module sensor_reply_frame_checker (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic [7:0]                rx_byte_i,
  input  wire logic                      end_of_frame_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic                           frame_good_o,
  output logic [srfc_pkg::PosW-1:0]      frame_length_o,
  output logic [15:0]                    reading_o,
  input  wire logic                      cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire logic [7:0]                reading_code_i
);
  import srfc_pkg::*;

  logic         in_vld_q;
  logic [7:0]   in_byte_q;
  logic         in_eof_q;
  logic         proc_fire;
  logic         res_free;

  frame_state_t st_q, st_d, st_n;
  logic         keep;
  logic [7:0]   rd_code_q;

  logic            res_vld_q;
  logic            res_good_q, res_good_d;
  logic [PosW-1:0] res_len_q;
  logic [15:0]     res_rd_q, res_rd_d;

  assign cfg_ready_o = 1'b1;

  // The result slot can take a new result when empty or when its transaction completes now.
  assign res_free   = !res_vld_q || out_ready_i;
  assign proc_fire  = in_vld_q && (!in_eof_q || res_free);
  assign in_ready_o = !in_vld_q || proc_fire;

  always_comb begin
    st_n = st_q;
    keep = st_q.pos < MaxFramePos;
    if (keep) begin
      if (st_q.pos >= PosW'(2)) begin
        st_n.crc = crc_feed(st_q.crc, st_q.older);
      end
      st_n.older = st_q.newer;
      st_n.newer = in_byte_q;
      if (st_q.pos == PosW'(0)) begin
        st_n.sync = (in_byte_q == SyncFirst);
      end else if (st_q.pos == PosW'(1)) begin
        st_n.sync = st_q.sync && (in_byte_q == SyncSecond);
      end else if (st_q.pos == PosW'(2)) begin
        st_n.code = in_byte_q;
      end else if (st_q.pos == PosW'(3)) begin
        st_n.rd_high = in_byte_q;
      end else if (st_q.pos == PosW'(4)) begin
        st_n.rd_low = in_byte_q;
      end
      st_n.pos = st_q.pos + PosW'(1);
    end
  end

  always_comb begin
    res_good_d = (st_n.pos >= PosW'(2)) && st_n.sync &&
                 (st_n.crc[7:0] == st_n.older) && (st_n.crc[15:8] == st_n.newer);
    res_rd_d   = (res_good_d && (st_n.code == rd_code_q)) ? {st_n.rd_high, st_n.rd_low}
                                                          : 16'h0000;
    st_d       = st_q;
    if (proc_fire) begin
      st_d = in_eof_q ? FrameClear : st_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
      st_q      <= FrameClear;
      rd_code_q <= ReadingCodeReset;
    end else begin
      st_q <= st_d;
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (proc_fire && in_eof_q) begin
        res_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        res_vld_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        rd_code_q <= reading_code_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= rx_byte_i;
      in_eof_q  <= end_of_frame_i;
    end
    if (proc_fire && in_eof_q) begin
      res_good_q <= res_good_d;
      res_len_q  <= st_n.pos;
      res_rd_q   <= res_rd_d;
    end
  end

  assign out_valid_o    = res_vld_q;
  assign frame_good_o   = res_good_q;
  assign frame_length_o = res_len_q;
  assign reading_o      = res_rd_q;

  a_pos_capped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.pos <= MaxFramePos)
    else $error("byte position ran past the frame limit");

  a_reading_needs_good: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (reading_o != 16'h0000) |-> frame_good_o)
    else $error("nonzero reading on a bad reply");

  a_good_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_good_o |-> (frame_length_o >= PosW'(2)) &&
                                    (frame_length_o <= MaxFramePos))
    else $error("good reply with impossible length");

  a_stalled_last_byte_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !proc_fire |=> in_vld_q && $stable(in_byte_q) && $stable(in_eof_q))
    else $error("stalled byte lost from the input register");

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc_fire && in_eof_q |=> (st_q.pos == PosW'(0)) && (st_q.crc == CrcInit) && res_vld_q)
    else $error("frame state not cleared after the last byte");

endmodule

`default_nettype wire
